/* src/rdt_pkg.sv */
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared types and constants of the triangle rasterizer with depth test.
// ----------------------------------------------------------------------------
package rdt_pkg;

   localparam int COORD_W     = 12;
   localparam int DEPTH_W     = 32;
   localparam int AREA_W      = 27;
   localparam int MAG_W       = 26;
   localparam int NUM_W       = MAG_W + DEPTH_W;
   localparam int DIV_CNT_W   = 5;
   localparam int LINE_W      = 16;
   localparam int REQ_DATA_W  = 168;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_ADDR_W  = 3;

   localparam int DEF_SCREEN_WIDTH  = 256;
   localparam int DEF_SCREEN_HEIGHT = 256;

   localparam logic [DEPTH_W-1:0] DEPTH_FAR = '1;

   // Register index carried in address bit 2
   localparam logic CSR_WIREFRAME_IDX = 1'b0;

   // Index of the last edge, product term and line of a triangle
   localparam logic [1:0] LAST_TERM = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_DRAW  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_CLEAR,
      CMD_FILL,
      CMD_WIRE,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                kind;
      logic signed [COORD_W-1:0]   ax;
      logic signed [COORD_W-1:0]   ay;
      logic signed [COORD_W-1:0]   bx;
      logic signed [COORD_W-1:0]   by;
      logic signed [COORD_W-1:0]   cx;
      logic signed [COORD_W-1:0]   cy;
      logic [DEPTH_W-1:0]          az;
      logic [DEPTH_W-1:0]          bz;
      logic [DEPTH_W-1:0]          cz;
      logic                        area_neg;
      logic [MAG_W-1:0]            amag;
      logic signed [COORD_W-1:0]   lox;
      logic signed [COORD_W-1:0]   hix;
      logic signed [COORD_W-1:0]   loy;
      logic signed [COORD_W-1:0]   hiy;
   } cmd_desc_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_FILL_EDGE,
      ST_FILL_MUL,
      ST_FILL_DIV,
      ST_FILL_RD,
      ST_FILL_CMP,
      ST_LINE_SETUP,
      ST_LINE_STEP,
      ST_READ_RD,
      ST_READ_OUT,
      ST_RESP
   } back_state_type;

endpackage

/* src/rdt_front.sv */
// ----------------------------------------------------------------------------
// rdt_front
// Accepts commands, holds the mode register and classifies each command
// (area, clamped bounding box, on-screen check) into a queue descriptor.
// ----------------------------------------------------------------------------
module rdt_front import rdt_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   input  logic [1:0]              req_tuser,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output logic                    q_push,
   output cmd_desc_type            q_data,
   input  logic                    q_full,
   input  back_status_type         status
);

   logic                       wireframe_ff;
   logic                       wireframe_in;
   logic signed [COORD_W-1:0]  ax, ay, bx, by, cx, cy;
   logic signed [COORD_W-1:0]  minx, maxx, miny, maxy;
   logic signed [COORD_W:0]    lox, hix, loy, hiy;
   logic signed [COORD_W:0]    scr_w_last, scr_h_last;
   logic signed [COORD_W:0]    dbx, dby, dcx, dcy;
   logic signed [AREA_W-1:0]   area;
   logic signed [AREA_W-1:0]   prod_a, prod_b;
   logic                       box_empty;
   logic                       read_on;

   // Register port: one mode bit
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_WIREFRAME_IDX) ? {31'd0, wireframe_ff} : 32'd0;

   always_comb begin
      wireframe_in = wireframe_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == CSR_WIREFRAME_IDX) begin
         wireframe_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wireframe_ff <= 1'b0;
      end else begin
         wireframe_ff <= wireframe_in;
      end
   end

   // Unpack vertices
   assign ax = $signed(req_tdata[11:0]);
   assign ay = $signed(req_tdata[23:12]);
   assign bx = $signed(req_tdata[35:24]);
   assign by = $signed(req_tdata[47:36]);
   assign cx = $signed(req_tdata[59:48]);
   assign cy = $signed(req_tdata[71:60]);

   // Twice the signed area of the triangle
   always_comb begin
      dbx    = 13'(bx) - 13'(ax);
      dby    = 13'(by) - 13'(ay);
      dcx    = 13'(cx) - 13'(ax);
      dcy    = 13'(cy) - 13'(ay);
      prod_a = dbx * dcy;
      prod_b = dby * dcx;
      area   = prod_a - prod_b;
   end

   // Bounding box clamped to the screen
   always_comb begin
      minx = ax;
      maxx = ax;
      miny = ay;
      maxy = ay;
      if (bx < minx) minx = bx;
      if (cx < minx) minx = cx;
      if (bx > maxx) maxx = bx;
      if (cx > maxx) maxx = cx;
      if (by < miny) miny = by;
      if (cy < miny) miny = cy;
      if (by > maxy) maxy = by;
      if (cy > maxy) maxy = cy;
      scr_w_last = $signed(13'(SCREEN_WIDTH - 1));
      scr_h_last = $signed(13'(SCREEN_HEIGHT - 1));
      lox = (minx < 0) ? '0 : 13'(minx);
      loy = (miny < 0) ? '0 : 13'(miny);
      hix = (13'(maxx) > scr_w_last) ? scr_w_last : 13'(maxx);
      hiy = (13'(maxy) > scr_h_last) ? scr_h_last : 13'(maxy);
      box_empty = (lox > hix) || (loy > hiy);
      read_on = (ax >= 0) && (13'(ax) <= scr_w_last) && (ay >= 0) && (13'(ay) <= scr_h_last);
   end

   // Classify into a queue descriptor
   always_comb begin
      q_data          = '0;
      q_data.ax       = ax;
      q_data.ay       = ay;
      q_data.bx       = bx;
      q_data.by       = by;
      q_data.cx       = cx;
      q_data.cy       = cy;
      q_data.az       = req_tdata[103:72];
      q_data.bz       = req_tdata[135:104];
      q_data.cz       = req_tdata[167:136];
      q_data.area_neg = area[AREA_W-1];
      q_data.amag     = MAG_W'(area[AREA_W-1] ? -area : area);
      q_data.lox      = COORD_W'(lox);
      q_data.hix      = COORD_W'(hix);
      q_data.loy      = COORD_W'(loy);
      q_data.hiy      = COORD_W'(hiy);
      unique case (opcode_type'(req_tuser))
         OP_CLEAR: q_data.kind = CMD_CLEAR;
         OP_DRAW: begin
            if (wireframe_ff) begin
               q_data.kind = CMD_WIRE;
            end else if (area == 0 || box_empty) begin
               q_data.kind = CMD_NOP;
            end else begin
               q_data.kind = CMD_FILL;
            end
         end
         OP_READ: q_data.kind = read_on ? CMD_READ : CMD_NOP;
         default: q_data.kind = CMD_NOP;
      endcase
   end

   // Hold off while the queue is full or the stores are being swept after reset
   assign req_tready = !q_full && !status.clearing;
   assign q_push     = req_tvalid && req_tready;

endmodule

/* src/rdt_queue.sv */
// ----------------------------------------------------------------------------
// rdt_queue
// Two-entry descriptor queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module rdt_queue import rdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_desc_type  push_data,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output cmd_desc_type  head_data
);

   cmd_desc_type  entry_ff [2];
   logic          wptr_ff, rptr_ff;
   logic          wptr_in, rptr_in;
   logic [1:0]    count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rptr_ff];

   // Advance pointers and count
   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

/* src/rdt_back.sv */
// ----------------------------------------------------------------------------
// rdt_back
// Command sequencer: store sweep, pixel walk with edge test, bit-serial
// depth divide and depth test, line stepping, pixel read and result register.
// ----------------------------------------------------------------------------
module rdt_back import rdt_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  cmd_desc_type            head_data,
   output logic                    pop,
   output back_status_type         status,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int XW        = $clog2(SCREEN_WIDTH);
   localparam int YW        = $clog2(SCREEN_HEIGHT);
   localparam int AW        = XW + YW;
   localparam int MEM_DEPTH = 1 << AW;

   back_state_type  state_ff, state_in;

   // Stores
   logic                lit_mem   [MEM_DEPTH];
   logic [DEPTH_W-1:0]  depth_mem [MEM_DEPTH];
   logic                lit_rd_ff;
   logic [DEPTH_W-1:0]  depth_rd_ff;
   logic [AW-1:0]       mem_addr;
   logic                lit_we, lit_wd;
   logic                depth_we;
   logic [DEPTH_W-1:0]  depth_wd;

   // Control and datapath registers
   cmd_desc_type               cmd_ff, cmd_in;
   logic                       init_ff, init_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic signed [COORD_W-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [1:0]                 k_ff, k_in;
   logic                       cov_ff, cov_in;
   logic [MAG_W-1:0]           emag_ff [3];
   logic [MAG_W-1:0]           emag_in [3];
   logic [NUM_W-1:0]           acc_ff, acc_in;
   logic [MAG_W-1:0]           rem_ff, rem_in;
   logic [DEPTH_W-1:0]         quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]       dcnt_ff, dcnt_in;
   logic [1:0]                 line_ff, line_in;
   logic signed [LINE_W-1:0]   ldx_ff, ldx_in, ldy_ff, ldy_in, lerr_ff, lerr_in;
   logic                       lsxn_ff, lsxn_in, lsyn_ff, lsyn_in;
   logic signed [COORD_W-1:0]  lex_ff, lex_in, ley_ff, ley_in;
   logic                       res_lit_ff, res_lit_in;
   logic [DEPTH_W-1:0]         res_depth_ff, res_depth_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_lit_ff, rsp_lit_in;
   logic [DEPTH_W-1:0]         rsp_depth_ff, rsp_depth_in;

   // Shared combinational terms
   logic signed [COORD_W-1:0]  xs, ys, xt, yt;
   logic signed [COORD_W:0]    e_dy, e_px, e_dx, e_py;
   logic signed [AREA_W-2:0]   e_p0, e_p1;
   logic signed [AREA_W-1:0]   edge_v;
   logic                       agree, cov_final;
   logic [MAG_W-1:0]           edge_mag;
   logic [DEPTH_W-1:0]         z_sel;
   logic [NUM_W-1:0]           prod, acc_sum;
   logic [MAG_W:0]             div_trial;
   logic                       div_bit;
   logic                       pix_last, row_last, clr_last, resp_load;
   logic signed [COORD_W-1:0]  lx0, ly0, lx1, ly1;
   logic signed [LINE_W-1:0]   ld_x, ld_y, le2;
   logic                       lc1, lc2, line_end, line_on;

   assign status.clearing = init_ff;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = {7'd0, rsp_depth_ff, rsp_lit_ff};

   // Edge term, product term and divide step of the fill walk
   always_comb begin
      case (k_ff)
         2'd0:    begin xs = cmd_ff.bx; ys = cmd_ff.by; xt = cmd_ff.cx; yt = cmd_ff.cy; end
         2'd1:    begin xs = cmd_ff.cx; ys = cmd_ff.cy; xt = cmd_ff.ax; yt = cmd_ff.ay; end
         default: begin xs = cmd_ff.ax; ys = cmd_ff.ay; xt = cmd_ff.bx; yt = cmd_ff.by; end
      endcase
      case (k_ff)
         2'd0:    z_sel = cmd_ff.az;
         2'd1:    z_sel = cmd_ff.bz;
         default: z_sel = cmd_ff.cz;
      endcase
      e_dy      = 13'(ys) - 13'(yt);
      e_px      = 13'(cur_x_ff) - 13'(xs);
      e_dx      = 13'(xt) - 13'(xs);
      e_py      = 13'(cur_y_ff) - 13'(ys);
      e_p0      = e_dy * e_px;
      e_p1      = e_dx * e_py;
      edge_v    = AREA_W'(e_p0) + AREA_W'(e_p1);
      agree     = (edge_v == 0) || (edge_v[AREA_W-1] == cmd_ff.area_neg);
      cov_final = cov_ff && agree;
      edge_mag  = MAG_W'(edge_v[AREA_W-1] ? -edge_v : edge_v);
      prod      = emag_ff[k_ff] * z_sel;
      acc_sum   = acc_ff + prod;
      div_trial = {rem_ff, quo_ff[DEPTH_W-1]} - {1'b0, cmd_ff.amag};
      div_bit   = !div_trial[MAG_W];
      row_last  = (cur_x_ff == cmd_ff.hix);
      pix_last  = row_last && (cur_y_ff == cmd_ff.hiy);
      clr_last  = &clr_ff;
      resp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);
   end

   // Line endpoints and Bresenham step
   always_comb begin
      case (line_ff)
         2'd0:    begin lx0 = cmd_ff.ax; ly0 = cmd_ff.ay; lx1 = cmd_ff.bx; ly1 = cmd_ff.by; end
         2'd1:    begin lx0 = cmd_ff.bx; ly0 = cmd_ff.by; lx1 = cmd_ff.cx; ly1 = cmd_ff.cy; end
         default: begin lx0 = cmd_ff.cx; ly0 = cmd_ff.cy; lx1 = cmd_ff.ax; ly1 = cmd_ff.ay; end
      endcase
      ld_x     = LINE_W'(lx1) - LINE_W'(lx0);
      ld_y     = LINE_W'(ly1) - LINE_W'(ly0);
      le2      = lerr_ff <<< 1;
      lc1      = le2 > -ldy_ff;
      lc2      = le2 < ldx_ff;
      line_end = (cur_x_ff == lex_ff) && (cur_y_ff == ley_ff);
      line_on  = !cur_x_ff[COORD_W-1] && ({1'b0, cur_x_ff} < (COORD_W+1)'(SCREEN_WIDTH))
              && !cur_y_ff[COORD_W-1] && ({1'b0, cur_y_ff} < (COORD_W+1)'(SCREEN_HEIGHT));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               unique case (head_data.kind)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_FILL:  state_in = ST_FILL_EDGE;
                  CMD_WIRE:  state_in = ST_LINE_SETUP;
                  CMD_READ:  state_in = ST_READ_RD;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_last) state_in = init_ff ? ST_IDLE : ST_RESP;
         end
         ST_FILL_EDGE: begin
            if (k_ff == LAST_TERM) begin
               if (cov_final)     state_in = ST_FILL_MUL;
               else if (pix_last) state_in = ST_RESP;
            end
         end
         ST_FILL_MUL: begin
            if (k_ff == LAST_TERM) state_in = ST_FILL_DIV;
         end
         ST_FILL_DIV: begin
            if (&dcnt_ff) state_in = ST_FILL_RD;
         end
         ST_FILL_RD:    state_in = ST_FILL_CMP;
         ST_FILL_CMP:   state_in = pix_last ? ST_RESP : ST_FILL_EDGE;
         ST_LINE_SETUP: state_in = ST_LINE_STEP;
         ST_LINE_STEP: begin
            if (line_end) state_in = (line_ff == LAST_TERM) ? ST_RESP : ST_LINE_SETUP;
         end
         ST_READ_RD:    state_in = ST_READ_OUT;
         ST_READ_OUT:   state_in = ST_RESP;
         ST_RESP: begin
            if (resp_load) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs: queue pop and store writes
   always_comb begin
      pop      = 1'b0;
      lit_we   = 1'b0;
      lit_wd   = 1'b0;
      depth_we = 1'b0;
      depth_wd = DEPTH_FAR;
      mem_addr = {cur_y_ff[YW-1:0], cur_x_ff[XW-1:0]};
      unique case (state_ff)
         ST_IDLE: pop = head_valid;
         ST_CLEAR: begin
            mem_addr = clr_ff;
            lit_we   = 1'b1;
            depth_we = 1'b1;
         end
         ST_FILL_CMP: begin
            if (quo_ff < depth_rd_ff) begin
               lit_we   = 1'b1;
               lit_wd   = 1'b1;
               depth_we = 1'b1;
               depth_wd = quo_ff;
            end
         end
         ST_LINE_STEP: begin
            lit_we = line_on;
            lit_wd = 1'b1;
         end
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      cmd_in       = cmd_ff;
      init_in      = init_ff;
      clr_in       = clr_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      k_in         = k_ff;
      cov_in       = cov_ff;
      emag_in      = emag_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      line_in      = line_ff;
      ldx_in       = ldx_ff;
      ldy_in       = ldy_ff;
      lerr_in      = lerr_ff;
      lsxn_in      = lsxn_ff;
      lsyn_in      = lsyn_ff;
      lex_in       = lex_ff;
      ley_in       = ley_ff;
      res_lit_in   = res_lit_ff;
      res_depth_in = res_depth_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd_in       = head_data;
            res_lit_in   = 1'b0;
            res_depth_in = '0;
            k_in         = '0;
            cov_in       = 1'b1;
            acc_in       = '0;
            line_in      = '0;
            if (head_data.kind == CMD_FILL) begin
               cur_x_in = head_data.lox;
               cur_y_in = head_data.loy;
            end else begin
               cur_x_in = head_data.ax;
               cur_y_in = head_data.ay;
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_last) init_in = 1'b0;
         end
         ST_FILL_EDGE: begin
            emag_in[k_ff] = edge_mag;
            cov_in        = cov_final;
            k_in          = k_ff + 1'b1;
            if (k_ff == LAST_TERM) begin
               k_in   = '0;
               acc_in = '0;
               if (!cov_final) begin
                  cov_in = 1'b1;
                  if (row_last) begin
                     cur_x_in = cmd_ff.lox;
                     cur_y_in = cur_y_ff + 1'b1;
                  end else begin
                     cur_x_in = cur_x_ff + 1'b1;
                  end
               end
            end
         end
         ST_FILL_MUL: begin
            acc_in = acc_sum;
            k_in   = k_ff + 1'b1;
            if (k_ff == LAST_TERM) begin
               k_in    = '0;
               rem_in  = acc_sum[NUM_W-1:DEPTH_W];
               quo_in  = acc_sum[DEPTH_W-1:0];
               dcnt_in = '0;
            end
         end
         ST_FILL_DIV: begin
            rem_in  = div_bit ? div_trial[MAG_W-1:0] : {rem_ff[MAG_W-2:0], quo_ff[DEPTH_W-1]};
            quo_in  = {quo_ff[DEPTH_W-2:0], div_bit};
            dcnt_in = dcnt_ff + 1'b1;
         end
         ST_FILL_CMP: begin
            k_in   = '0;
            cov_in = 1'b1;
            acc_in = '0;
            if (row_last) begin
               cur_x_in = cmd_ff.lox;
               cur_y_in = cur_y_ff + 1'b1;
            end else begin
               cur_x_in = cur_x_ff + 1'b1;
            end
         end
         ST_LINE_SETUP: begin
            cur_x_in = lx0;
            cur_y_in = ly0;
            lex_in   = lx1;
            ley_in   = ly1;
            ldx_in   = ld_x[LINE_W-1] ? -ld_x : ld_x;
            ldy_in   = ld_y[LINE_W-1] ? -ld_y : ld_y;
            lerr_in  = (ld_x[LINE_W-1] ? -ld_x : ld_x) - (ld_y[LINE_W-1] ? -ld_y : ld_y);
            lsxn_in  = !(lx0 < lx1);
            lsyn_in  = !(ly0 < ly1);
         end
         ST_LINE_STEP: begin
            if (line_end) begin
               line_in = line_ff + 1'b1;
            end else begin
               lerr_in = lerr_ff - (lc1 ? ldy_ff : '0) + (lc2 ? ldx_ff : '0);
               if (lc1) cur_x_in = lsxn_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
               if (lc2) cur_y_in = lsyn_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
            end
         end
         ST_READ_OUT: begin
            res_lit_in   = lit_rd_ff;
            res_depth_in = depth_rd_ff;
         end
         default: ;
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_lit_in   = rsp_lit_ff;
      rsp_depth_in = rsp_depth_ff;
      if (resp_load) begin
         rsp_valid_in = 1'b1;
         rsp_lit_in   = res_lit_ff;
         rsp_depth_in = res_depth_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      k_ff         <= k_in;
      cov_ff       <= cov_in;
      emag_ff      <= emag_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dcnt_ff      <= dcnt_in;
      line_ff      <= line_in;
      ldx_ff       <= ldx_in;
      ldy_ff       <= ldy_in;
      lerr_ff      <= lerr_in;
      lsxn_ff      <= lsxn_in;
      lsyn_ff      <= lsyn_in;
      lex_ff       <= lex_in;
      ley_ff       <= ley_in;
      res_lit_ff   <= res_lit_in;
      res_depth_ff <= res_depth_in;
      rsp_lit_ff   <= rsp_lit_in;
      rsp_depth_ff <= rsp_depth_in;
   end

   // Stores: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (lit_we) lit_mem[mem_addr] <= lit_wd;
      lit_rd_ff <= lit_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (depth_we) depth_mem[mem_addr] <= depth_wd;
      depth_rd_ff <= depth_mem[mem_addr];
   end

   // Nothing leaves the queue during the sweep after reset
   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !pop)
      else $error("command taken during reset sweep");

   // A fill write only ever lowers the stored depth
   a_depth_lowers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL_CMP && depth_we) |-> (depth_wd < depth_rd_ff))
      else $error("fill write does not lower depth");

   // The fill walk stays inside the clamped box
   a_walk_in_box: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL_RD) |-> (cur_x_ff >= cmd_ff.lox && cur_x_ff <= cmd_ff.hix
                                    && cur_y_ff >= cmd_ff.loy && cur_y_ff <= cmd_ff.hiy))
      else $error("fill walk left the box");

   // Loading a result always presents it next cycle
   a_resp_shown: assert property (@(posedge clock) disable iff (reset)
      resp_load |=> rsp_valid_ff)
      else $error("result lost");

endmodule

/* src/triangle_rasterizer_depth_test.sv */
// ----------------------------------------------------------------------------
// triangle_rasterizer_depth_test
// Triangle rasterizer with a one-bit framebuffer and a Q16.16 depth store.
// ----------------------------------------------------------------------------
// Every command gives one result. Clear writes every store entry in turn,
// 2**(clog2(W)+clog2(H)) entries (65536 at 256x256); the same sweep runs
// after reset, while no command is accepted. Read addresses the stores,
// registers the pixel and loads the result. A filled triangle walks its
// clamped bounding box one pixel at a time through the single-port store:
// a pixel outside the triangle ends after its edge terms; one inside also
// takes the edge-depth products, the bit-serial divide, a memory read and
// the depth test. A wireframe triangle sets up each line and then steps it.
// A two-entry queue lets commands be taken while the previous one runs.
// ----------------------------------------------------------------------------
module triangle_rasterizer_depth_test import rdt_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   // tdata: vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x,
   //        vertex_c_y, vertex_a_depth, vertex_b_depth, vertex_c_depth
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // tuser: opcode
   input  logic [1:0]              req_tuser,
   // tdata: pixel_lit, pixel_depth, zero fill
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   logic             q_push, q_full, q_pop, q_head_valid;
   cmd_desc_type     q_data, q_head;
   back_status_type  status;

   rdt_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .q_push      (q_push),
      .q_data      (q_data),
      .q_full      (q_full),
      .status      (status)
   );

   rdt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_data),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head)
   );

   rdt_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_data  (q_head),
      .pop        (q_pop),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* verif/triangle_rasterizer_depth_test_tb.sv */
// ----------------------------------------------------------------------------
// triangle_rasterizer_depth_test_tb
// Self-checking bench for the triangle rasterizer with depth test.
// ----------------------------------------------------------------------------
// A queue of commands feeds a clocked driver on the request stream. Each
// accepted command updates a local framebuffer and depth store, and the
// response it should produce is queued. A monitor compares every response
// transfer with the oldest queued one. The run covers filled and wireframe
// modes, both stall patterns on either side and a stretch with no stalls.
// ----------------------------------------------------------------------------
module triangle_rasterizer_depth_test_tb import rdt_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCR_W      = 256;
   localparam int SCR_H      = 256;
   localparam int LIMIT      = 12000000;
   localparam logic [CSR_ADDR_W-1:0] WIRE_ADDR = {CSR_WIREFRAME_IDX, 2'b00};

   typedef struct packed {
      opcode_type                op;
      logic signed [COORD_W-1:0] ax, ay, bx, by, cx, cy;
      logic [DEPTH_W-1:0]        az, bz, cz;
   } rast_cmd_type;

   typedef struct packed {
      logic               lit;
      logic [DEPTH_W-1:0] depth;
   } pixel_rsp_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   triangle_rasterizer_depth_test u_dut (.*);

   always #6 clock = ~clock;

   // local copy of the block's stores and register
   logic               fb_lit [SCR_W*SCR_H];
   logic [DEPTH_W-1:0] fb_depth [SCR_W*SCR_H];
   logic               wire_mode;

   rast_cmd_type  pending_cmds [$];
   pixel_rsp_type expected_pixels [$];
   rast_cmd_type  cur_cmd;
   logic          req_took = 0;
   int            send_idle_pct, recv_idle_pct;
   int            errors = 0, cycles = 0, n_cmds = 0, n_lit_reads = 0, n_draws = 0;

   function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                      longint px, longint py);
      return (ay - by) * px + (bx - ax) * py + ax * by - bx * ay;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic bit visible(int x, int y);
      return x >= 0 && x < SCR_W && y >= 0 && y < SCR_H;
   endfunction

   task automatic plot_line(int x0, int y0, int x1, int y1);
      int dx, dy, sx, sy, err, e2;
      dx = x1 > x0 ? x1 - x0 : x0 - x1;
      dy = y1 > y0 ? y1 - y0 : y0 - y1;
      sx = x0 < x1 ? 1 : -1;
      sy = y0 < y1 ? 1 : -1;
      err = dx - dy;
      forever begin
         if (visible(x0, y0)) fb_lit[y0*SCR_W + x0] = 1'b1;
         if (x0 == x1 && y0 == y1) break;
         e2 = 2 * err;
         if (e2 > -dy) begin
            err -= dy;
            x0 += sx;
         end
         if (e2 < dx) begin
            err += dx;
            y0 += sy;
         end
      end
   endtask

   task automatic fill_triangle(rast_cmd_type c);
      longint area, e0, e1, e2;
      longint unsigned amag, num;
      logic [DEPTH_W-1:0] z;
      int lox, hix, loy, hiy, idx;
      area = edge_fn(c.ax, c.ay, c.bx, c.by, c.cx, c.cy);
      if (area == 0) return;
      lox = c.ax; hix = c.ax; loy = c.ay; hiy = c.ay;
      if (c.bx < lox) lox = c.bx;
      if (c.cx < lox) lox = c.cx;
      if (c.bx > hix) hix = c.bx;
      if (c.cx > hix) hix = c.cx;
      if (c.by < loy) loy = c.by;
      if (c.cy < loy) loy = c.cy;
      if (c.by > hiy) hiy = c.by;
      if (c.cy > hiy) hiy = c.cy;
      if (lox < 0) lox = 0;
      if (loy < 0) loy = 0;
      if (hix > SCR_W - 1) hix = SCR_W - 1;
      if (hiy > SCR_H - 1) hiy = SCR_H - 1;
      amag = magnitude(area);
      for (int y = loy; y <= hiy; y++) begin
         for (int x = lox; x <= hix; x++) begin
            e0 = edge_fn(c.bx, c.by, c.cx, c.cy, x, y);
            e1 = edge_fn(c.cx, c.cy, c.ax, c.ay, x, y);
            e2 = edge_fn(c.ax, c.ay, c.bx, c.by, x, y);
            if ((e0 != 0 && ((e0 > 0) != (area > 0))) ||
                (e1 != 0 && ((e1 > 0) != (area > 0))) ||
                (e2 != 0 && ((e2 > 0) != (area > 0)))) continue;
            num = magnitude(e0) * c.az + magnitude(e1) * c.bz + magnitude(e2) * c.cz;
            z = DEPTH_W'(num / amag);
            idx = y * SCR_W + x;
            if (z < fb_depth[idx]) begin
               fb_depth[idx] = z;
               fb_lit[idx] = 1'b1;
            end
         end
      end
   endtask

   task automatic clear_store();
      foreach (fb_lit[i]) begin
         fb_lit[i] = 1'b0;
         fb_depth[i] = DEPTH_FAR;
      end
   endtask

   // apply one command to the local stores and queue its response
   task automatic predict_pixel(rast_cmd_type c);
      pixel_rsp_type r;
      r = '0;
      case (c.op)
         OP_CLEAR: clear_store();
         OP_DRAW: begin
            if (wire_mode) begin
               plot_line(c.ax, c.ay, c.bx, c.by);
               plot_line(c.bx, c.by, c.cx, c.cy);
               plot_line(c.cx, c.cy, c.ax, c.ay);
            end else begin
               fill_triangle(c);
            end
         end
         OP_READ: begin
            if (visible(c.ax, c.ay)) begin
               r.lit = fb_lit[c.ay*SCR_W + c.ax];
               r.depth = fb_depth[c.ay*SCR_W + c.ax];
               if (r.lit) n_lit_reads++;
            end
         end
         default: ;
      endcase
      expected_pixels = {expected_pixels, r};
   endtask

   // append one command to the pending list
   task automatic add_cmd(rast_cmd_type c);
      pending_cmds = {pending_cmds, c};
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // drive the request stream
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_cmd = pending_cmds.pop_front();
            req_tdata <= {cur_cmd.cz, cur_cmd.bz, cur_cmd.az, cur_cmd.cy, cur_cmd.cx,
                          cur_cmd.by, cur_cmd.bx, cur_cmd.ay, cur_cmd.ax};
            req_tuser <= cur_cmd.op;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // stall the response stream
   always @(negedge clock)
      rsp_tready <= !reset && $urandom_range(99) >= recv_idle_pct;

   // predict on each request transfer, check each response transfer
   always @(posedge clock) begin
      pixel_rsp_type want;
      cycles++;
      req_took <= req_tvalid && req_tready;
      if (req_tvalid && req_tready) begin
         predict_pixel(cur_cmd);
         n_cmds++;
         if (cur_cmd.op == OP_DRAW) n_draws++;
      end
      if (rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tdata[0] !== want.lit) report_mismatch("pixel_lit", rsp_tdata[0], want.lit);
            if (rsp_tdata[32:1] !== want.depth)
               report_mismatch("pixel_depth", rsp_tdata[32:1], want.depth);
         end
      end
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   function automatic rast_cmd_type make_cmd(opcode_type op, int ax, int ay, int bx, int by,
                                             int cx, int cy, logic [31:0] az,
                                             logic [31:0] bz, logic [31:0] cz);
      rast_cmd_type c;
      c.op = op;
      c.ax = COORD_W'(ax); c.ay = COORD_W'(ay);
      c.bx = COORD_W'(bx); c.by = COORD_W'(by);
      c.cx = COORD_W'(cx); c.cy = COORD_W'(cy);
      c.az = az; c.bz = bz; c.cz = cz;
      return c;
   endfunction

   function automatic logic [31:0] rand_depth();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(65535);
         2: return 32'hFFFF_FFFF;
         default: return 32'h0010_0000 + $urandom_range(32'h00FF_FFFF);
      endcase
   endfunction

   function automatic rast_cmd_type random_wide();
      logic [191:0] raw;
      rast_cmd_type c;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      c = raw[$bits(rast_cmd_type)-1:0];
      return c;
   endfunction

   // draws are mostly small triangles near the screen, most reads aim at the last one
   int anchor_x = 100, anchor_y = 100;

   function automatic rast_cmd_type random_cmd(bit wide_wire);
      rast_cmd_type c;
      int sel, span;
      sel = $urandom_range(99);
      if (sel < 45) begin
         span = $urandom_range(3) == 0 ? 12 : 6;
         anchor_x = $urandom_range(SCR_W + 8) - 8;
         anchor_y = $urandom_range(SCR_H + 8) - 8;
         c = make_cmd(OP_DRAW, anchor_x, anchor_y,
                      anchor_x + $urandom_range(2*span) - span,
                      anchor_y + $urandom_range(2*span) - span,
                      anchor_x + $urandom_range(2*span) - span,
                      anchor_y + $urandom_range(2*span) - span,
                      rand_depth(), rand_depth(), rand_depth());
         if (wide_wire && $urandom_range(9) == 0) begin
            c = random_wide();
            c.op = OP_DRAW;
         end
      end else if (sel < 85) begin
         c = random_wide();
         c.op = OP_READ;
         if (sel < 78) begin
            c.ax = COORD_W'(anchor_x + $urandom_range(12) - 6);
            c.ay = COORD_W'(anchor_y + $urandom_range(12) - 6);
         end
      end else if (sel < 98) begin
         c = random_wide();
         c.op = OP_NONE;
      end else begin
         c = random_wide();
         c.op = OP_CLEAR;
      end
      return c;
   endfunction

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_wire_mode(logic value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= WIRE_ADDR;
      csr_pwdata <= {31'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      wire_mode = value;
   endtask

   initial begin
      clear_store();
      wire_mode = 1'b0;
      send_idle_pct = 9;
      recv_idle_pct = 62;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // filled mode, directed corners and special cases
      write_wire_mode(1'b0);
      add_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_cmd(make_cmd(OP_READ, 255, 255, -1, -1, -1, -1, '1, '1, '1));
      add_cmd(make_cmd(OP_READ, -1, 0, 0, 0, 0, 0, 0, 0, 0));
      add_cmd(make_cmd(OP_READ, 256, 5, 0, 0, 0, 0, 0, 0, 0));
      add_cmd(make_cmd(OP_READ, -2048, 2047, 2047, -2048, 0, 0, 0, 0, 0));
      add_cmd(make_cmd(OP_READ, 2047, -2048, 0, 0, 0, 0, 0, 0, 0));
      add_cmd(make_cmd(OP_NONE, -2048, 2047, -2048, 2047, -2048, 2047, '1, '1, '1));
      // depth all ones never wins against a cleared pixel
      add_cmd(make_cmd(OP_DRAW, 10, 10, 16, 10, 10, 16, '1, '1, '1));
      add_cmd(make_cmd(OP_READ, 11, 11, 0, 0, 0, 0, 0, 0, 0));
      // both windings, then a nearer overlap and a farther one
      add_cmd(make_cmd(OP_DRAW, 10, 10, 10, 16, 16, 10, 32'h0005_0000,
                       32'h0001_8000, 32'hFFFF_FFFE));
      add_cmd(make_cmd(OP_DRAW, 10, 10, 16, 10, 10, 16, 0, 0, 0));
      add_cmd(make_cmd(OP_DRAW, 12, 12, 20, 12, 12, 20, '1, 32'h1234_5678,
                       32'h0000_0001));
      add_cmd(make_cmd(OP_READ, 11, 11, 0, 0, 0, 0, 0, 0, 0));
      add_cmd(make_cmd(OP_READ, 13, 13, 0, 0, 0, 0, 0, 0, 0));
      // degenerate, fully off screen, and straddling the corners
      add_cmd(make_cmd(OP_DRAW, 30, 30, 35, 35, 40, 40, 1, 2, 3));
      add_cmd(make_cmd(OP_DRAW, -2048, 300, 2047, 2047, 0, 2000, 0, 0, 0));
      add_cmd(make_cmd(OP_DRAW, -2048, -2048, -3, -2048, -5, -1, 0, 0, 0));
      add_cmd(make_cmd(OP_DRAW, -5, -5, 6, -3, -2, 7, 100, 200, 300));
      add_cmd(make_cmd(OP_DRAW, 250, 250, 262, 252, 251, 263, 9, 8, 7));
      add_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_cmd(make_cmd(OP_READ, 255, 255, 0, 0, 0, 0, 0, 0, 0));
      add_cmd(make_cmd(OP_CLEAR, 2047, -1, 7, 7, 7, 7, '1, 0, '1));
      add_cmd(make_cmd(OP_READ, 13, 13, 0, 0, 0, 0, 0, 0, 0));
      repeat (50) add_cmd(random_cmd(1'b0));
      wait_drained();

      // wireframe, receiver stalls less than sender
      write_wire_mode(1'b1);
      send_idle_pct = 62;
      recv_idle_pct = 9;
      add_cmd(make_cmd(OP_DRAW, -2048, -2048, 2047, 2047, -2048, 2047, 0, 0, 0));
      add_cmd(make_cmd(OP_DRAW, 40, 40, 40, 40, 40, 40, 0, 0, 0));
      add_cmd(make_cmd(OP_DRAW, 250, 3, 300, 9, 200, -20, 0, 0, 0));
      add_cmd(make_cmd(OP_READ, 128, 128, 0, 0, 0, 0, 0, 0, 0));
      add_cmd(make_cmd(OP_READ, 40, 40, 0, 0, 0, 0, 0, 0, 0));
      repeat (35) add_cmd(random_cmd(1'b1));
      wait_drained();

      // no stalls, back to filled mode with a full drain midway, then wireframe
      write_wire_mode(1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (15) add_cmd(random_cmd(1'b0));
      wait_drained();
      repeat (15) add_cmd(random_cmd(1'b0));
      wait_drained();
      write_wire_mode(1'b1);
      repeat (10) add_cmd(random_cmd(1'b1));
      wait_drained();

      repeat (100) @(posedge clock);
      $display("%0d commands (%0d draws) in filled and wireframe modes, %0d lit reads",
               n_cmds, n_draws, n_lit_reads);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d responses missing", errors, expected_pixels.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
